// ===== rtl/core/sprite_quad_vertex_gen_assert.svh =====
// assertion macros shared by the sprite quad vertex generator
`ifndef SPRITE_QUAD_VERTEX_GEN_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_GEN_ASSERT_SVH

// condition holds in the same cycle
`define SQV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define SQV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sqv_pkg.sv =====
`default_nettype none

package sqv_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 112;

  // configuration register indexes
  localparam logic [3:0] REG_UV_LEFT   = 4'd0;
  localparam logic [3:0] REG_UV_TOP    = 4'd1;
  localparam logic [3:0] REG_UV_RIGHT  = 4'd2;
  localparam logic [3:0] REG_UV_BOTTOM = 4'd3;

  // defaults
  localparam int unsigned TRIG_BITS_DEF = 10;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // angle handling, degrees in Q9.7
  localparam int unsigned DEG_TURN   = 46080;
  localparam int unsigned ROUND_TURN = 23040;
  // floor(m / 45) as (m * RECIP_45) >> RECIP_SHIFT, exact for m below 2^28
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // trig and position constants
  localparam logic signed [16:0] COS_ONE = 17'sd32768;
  localparam logic signed [31:0] POS_MAX = 32'sd8388607;
  localparam logic signed [31:0] POS_MIN = -32'sd8388608;

  // vertex order TL, BL, BR, TL, TR, BR: bit i set where the corner is on the negative side
  localparam logic [2:0] LAST_VERTEX = 3'd5;
  localparam logic [5:0] NEG_X_MASK  = 6'b001011;
  localparam logic [5:0] NEG_Y_MASK  = 6'b011001;

  typedef struct packed {
    logic [11:0] sprite_width;
    logic [11:0] sprite_height;
    logic [15:0] scale_factor;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] offset_x;
    logic [23:0] offset_y;
    logic [16:0] angle_deg;
    logic [31:0] tint_color;
    logic        flip_x;
    logic        flip_y;
  } sprite_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } uv_t;

  // geometry carried down the front pipeline
  typedef struct packed {
    logic [27:0] hx;
    logic [27:0] hy;
    logic [24:0] cx;
    logic [24:0] cy;
    logic [31:0] color;
    logic [15:0] u_l;
    logic [15:0] u_r;
    logic [15:0] v_t;
    logic [15:0] v_b;
  } geom_t;

  // one sprite ready for vertex expansion
  typedef struct packed {
    logic [45:0] xa;   // hx * cos
    logic [45:0] xb;   // hy * sin
    logic [45:0] ya;   // hx * sin
    logic [45:0] yb;   // hy * cos
    logic [24:0] cx;
    logic [24:0] cy;
    logic [31:0] color;
    logic [15:0] u_l;
    logic [15:0] u_r;
    logic [15:0] v_t;
    logic [15:0] v_b;
  } item_t;

  // round half up of 32768*sin(2*pi*r/2^bits) for r in the first quadrant
  function automatic logic [14:0] quarter_sine(input logic [63:0] r, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    x  = (64'd2 * PI_Q30 * r) >> bits;
    x2 = (x * x) >> 30;
    s  = $signed(x);
    t  = ((x * x2) >> 30) / 64'd6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + $signed(t);
    if (s < 0) begin
      s = 0;
    end
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    return s[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sqv_queue.sv =====
`default_nettype none

`include "sprite_quad_vertex_gen_assert.svh"

module sqv_queue import sqv_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SQV_ASSERT_NOW(a_no_push_when_full, push, !full, "push into a full queue")
  `SQV_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "queue fill level out of range")

endmodule

`default_nettype wire

// ===== rtl/core/sqv_front.sv =====
`default_nettype none

module sqv_front import sqv_pkg::*; #(
  parameter int unsigned TRIG_TABLE_BITS = TRIG_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sprite_t in_sprite,
  input  uv_t     uv,
  output logic    out_valid,
  input  logic    out_ready,
  output item_t   out_item
);

  localparam int unsigned B       = TRIG_TABLE_BITS;
  localparam int unsigned QUARTER = 1 << (B - 2);
  localparam int unsigned AW      = B - 1;
  localparam int unsigned NUM_W   = 16 + B + 1;
  localparam int unsigned M_W     = NUM_W - 10;
  localparam int unsigned P_W     = M_W + RECIP_W;

  typedef logic [14:0] qsin_t [0:QUARTER];

  function automatic qsin_t build_qsin();
    qsin_t tab;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      tab[i] = quarter_sine(64'(i), B);
    end
    return tab;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  logic en;

  // stage 1: extents, centre, reduced angle, flipped texture corners
  logic              v1;
  geom_t             g1;
  logic [15:0]       a1;
  logic              z1;
  logic signed [18:0] ang19;
  logic signed [18:0] ang_red;
  geom_t             g_c;

  // stage 2: reciprocal product for the table index
  logic              v2;
  geom_t             g2;
  logic              z2;
  logic [P_W-1:0]    p2;
  logic [NUM_W-1:0]  num_c;
  logic [M_W-1:0]    m_c;

  // stage 3: table read
  logic              v3;
  geom_t             g3;
  logic              z3;
  logic [14:0]       mag_s3;
  logic [14:0]       mag_c3;
  logic              neg_s3;
  logic              neg_c3;
  logic [B-1:0]      k_s;
  logic [B-1:0]      k_c;
  logic [AW-1:0]     addr_s;
  logic [AW-1:0]     addr_c;

  // stage 4: signed sine and cosine
  logic              v4;
  geom_t             g4;
  logic signed [16:0] cs4;
  logic signed [16:0] sn4;
  logic signed [16:0] ms_c;
  logic signed [16:0] mc_c;

  // stage 5: corner products
  logic              v5;
  item_t             it5;
  logic signed [28:0] hxs;
  logic signed [28:0] hys;
  logic signed [45:0] xa_c;
  logic signed [45:0] xb_c;
  logic signed [45:0] ya_c;
  logic signed [45:0] yb_c;

  assign en        = !v5 || out_ready;
  assign in_ready  = en;
  assign out_valid = v5;
  assign out_item  = it5;

  // angle modulo a full turn by picking the candidate in range
  always_comb begin
    ang19 = {{2{in_sprite.angle_deg[16]}}, in_sprite.angle_deg};
    if (ang19 >= 19'sd46080) begin
      ang_red = ang19 - 19'sd46080;
    end else if (ang19 >= 19'sd0) begin
      ang_red = ang19;
    end else if (ang19 >= -19'sd46080) begin
      ang_red = ang19 + 19'sd46080;
    end else begin
      ang_red = ang19 + 19'sd92160;
    end
  end

  // geometry of the accepted sprite
  always_comb begin
    g_c.hx    = 28'(in_sprite.sprite_width) * 28'(in_sprite.scale_factor);
    g_c.hy    = 28'(in_sprite.sprite_height) * 28'(in_sprite.scale_factor);
    g_c.cx    = {in_sprite.pos_x[23], in_sprite.pos_x}
              + {in_sprite.offset_x[23], in_sprite.offset_x};
    g_c.cy    = {in_sprite.pos_y[23], in_sprite.pos_y}
              + {in_sprite.offset_y[23], in_sprite.offset_y};
    g_c.color = in_sprite.tint_color;
    g_c.u_l   = in_sprite.flip_x ? uv.right : uv.left;
    g_c.u_r   = in_sprite.flip_x ? uv.left : uv.right;
    g_c.v_t   = in_sprite.flip_y ? uv.bottom : uv.top;
    g_c.v_b   = in_sprite.flip_y ? uv.top : uv.bottom;
  end

  // index numerator scaled down by 1024, leaving a divide by 45
  assign num_c = (NUM_W'(a1) << B) + NUM_W'(ROUND_TURN);
  assign m_c   = num_c[NUM_W-1:10];

  // table index, cosine a quarter turn ahead, mirrored in odd quadrants
  assign k_s    = p2[RECIP_SHIFT+B-1:RECIP_SHIFT];
  assign k_c    = k_s + B'(QUARTER);
  assign addr_s = k_s[B-2] ? (AW'(QUARTER) - {1'b0, k_s[B-3:0]}) : {1'b0, k_s[B-3:0]};
  assign addr_c = k_c[B-2] ? (AW'(QUARTER) - {1'b0, k_c[B-3:0]}) : {1'b0, k_c[B-3:0]};

  assign ms_c = $signed({2'b00, mag_s3});
  assign mc_c = $signed({2'b00, mag_c3});

  assign hxs  = $signed({1'b0, g4.hx});
  assign hys  = $signed({1'b0, g4.hy});
  assign xa_c = hxs * cs4;
  assign xb_c = hys * sn4;
  assign ya_c = hxs * sn4;
  assign yb_c = hys * cs4;

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      g1     <= g_c;
      a1     <= ang_red[15:0];
      z1     <= (in_sprite.angle_deg == '0);

      g2     <= g1;
      z2     <= z1;
      p2     <= P_W'(m_c) * P_W'(RECIP_45);

      g3     <= g2;
      z3     <= z2;
      mag_s3 <= QSIN[addr_s];
      mag_c3 <= QSIN[addr_c];
      neg_s3 <= k_s[B-1];
      neg_c3 <= k_c[B-1];

      g4     <= g3;
      cs4    <= z3 ? COS_ONE : (neg_c3 ? -mc_c : mc_c);
      sn4    <= z3 ? 17'sd0 : (neg_s3 ? -ms_c : ms_c);

      it5.xa    <= xa_c;
      it5.xb    <= xb_c;
      it5.ya    <= ya_c;
      it5.yb    <= yb_c;
      it5.cx    <= g4.cx;
      it5.cy    <= g4.cy;
      it5.color <= g4.color;
      it5.u_l   <= g4.u_l;
      it5.u_r   <= g4.u_r;
      it5.v_t   <= g4.v_t;
      it5.v_b   <= g4.v_b;
    end
  end

  // stage valid bits, all stages move together
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sqv_back.sv =====
`default_nettype none

`include "sprite_quad_vertex_gen_assert.svh"

module sqv_back import sqv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  // floor((v + 2^15) / 2^16), saturated to 24 bits signed
  function automatic logic [23:0] round_sat(input logic signed [47:0] v);
    logic signed [47:0] t;
    logic signed [31:0] r;
    t = v + 48'sd32768;
    r = $signed(t[47:16]);
    if (r > POS_MAX) begin
      return POS_MAX[23:0];
    end else if (r < POS_MIN) begin
      return POS_MIN[23:0];
    end
    return r[23:0];
  endfunction

  logic [2:0]          vcnt;
  logic                neg_x;
  logic                neg_y;
  logic signed [47:0]  cx48;
  logic signed [47:0]  cy48;
  logic signed [47:0]  xa48;
  logic signed [47:0]  xb48;
  logic signed [47:0]  ya48;
  logic signed [47:0]  yb48;
  logic signed [47:0]  sum_x;
  logic signed [47:0]  sum_y;

  // sum stage
  logic                s_valid;
  logic signed [47:0]  s_x;
  logic signed [47:0]  s_y;
  logic [31:0]         s_color;
  logic [15:0]         s_u;
  logic [15:0]         s_v;
  logic                s_last;
  logic                s_load;

  // output stage
  logic                o_valid;
  logic [23:0]         o_x;
  logic [23:0]         o_y;
  logic [31:0]         o_color;
  logic [15:0]         o_u;
  logic [15:0]         o_v;
  logic                o_last;
  logic                o_load;

  assign o_load = !o_valid || m_tready;
  assign s_load = !s_valid || o_load;
  assign q_pop  = s_load && q_valid && (vcnt == LAST_VERTEX);

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_v, o_u, o_color, o_y, o_x};
  assign m_tlast  = o_last;

  // corner of the current vertex
  assign neg_x = NEG_X_MASK[vcnt];
  assign neg_y = NEG_Y_MASK[vcnt];

  assign cx48 = $signed({{7{q_item.cx[24]}}, q_item.cx, 16'h0000});
  assign cy48 = $signed({{7{q_item.cy[24]}}, q_item.cy, 16'h0000});
  assign xa48 = $signed({{2{q_item.xa[45]}}, q_item.xa});
  assign xb48 = $signed({{2{q_item.xb[45]}}, q_item.xb});
  assign ya48 = $signed({{2{q_item.ya[45]}}, q_item.ya});
  assign yb48 = $signed({{2{q_item.yb[45]}}, q_item.yb});

  // x = c + px*cos - py*sin, y = c + px*sin + py*cos
  assign sum_x = cx48 + (neg_x ? -xa48 : xa48) + (neg_y ? xb48 : -xb48);
  assign sum_y = cy48 + (neg_x ? -ya48 : ya48) + (neg_y ? -yb48 : yb48);

  // payload registers
  always_ff @(posedge clk) begin
    if (s_load) begin
      s_x     <= sum_x;
      s_y     <= sum_y;
      s_color <= q_item.color;
      s_u     <= neg_x ? q_item.u_l : q_item.u_r;
      s_v     <= neg_y ? q_item.v_t : q_item.v_b;
      s_last  <= (vcnt == LAST_VERTEX);
    end
    if (o_load) begin
      o_x     <= round_sat(s_x);
      o_y     <= round_sat(s_y);
      o_color <= s_color;
      o_u     <= s_u;
      o_v     <= s_v;
      o_last  <= s_last;
    end
  end

  // vertex counter and stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt    <= '0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s_load) begin
        s_valid <= q_valid;
        if (q_valid) begin
          vcnt <= (vcnt == LAST_VERTEX) ? 3'd0 : vcnt + 3'd1;
        end
      end
      if (o_load) begin
        o_valid <= s_valid;
      end
    end
  end

  `SQV_ASSERT_NOW(a_mid_quad_has_item, vcnt != 3'd0, q_valid, "vertex count runs without a sprite")
  `SQV_ASSERT_NOW(a_count_range, 1'b1, vcnt <= LAST_VERTEX, "vertex count beyond sixth vertex")
  `SQV_ASSERT_NEXT(a_last_marked, s_load && q_valid && (vcnt == LAST_VERTEX),
                   s_valid && s_last, "sixth vertex not marked last")

endmodule

`default_nettype wire

// ===== rtl/core/sprite_quad_vertex_gen.sv =====
// sprites pass the front pipeline, the queue, then the back end sum and output stages
// throughput: one vertex per cycle while m_tready is high, set by the vertex counter
//   of the back end walking the six corners of the sprite at the queue head
// the front pipeline takes a new sprite every cycle while the two-entry queue has room
// reset: synchronous, clears all valid bits, queue pointers, the vertex counter and
//   sets the texture rectangle to left 0, top 0, right 65535, bottom 65535
`default_nettype none

module sprite_quad_vertex_gen import sqv_pkg::*; #(
  parameter int unsigned TRIG_TABLE_BITS = TRIG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // sprite_width, sprite_height, scale_factor, pos_x, pos_y, offset_x, offset_y,
  // angle_deg, tint_color, zero pad
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // flip_x, flip_y
  input  logic [1:0]             s_tuser,
  // vertex_x, vertex_y, vertex_color, vertex_u, vertex_v
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  sprite_t sprite;
  uv_t     uv;
  item_t   f_item;
  item_t   q_item;
  logic    f_valid;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;

  // unpack the input transaction
  always_comb begin
    sprite.sprite_width  = s_tdata[11:0];
    sprite.sprite_height = s_tdata[23:12];
    sprite.scale_factor  = s_tdata[39:24];
    sprite.pos_x         = s_tdata[63:40];
    sprite.pos_y         = s_tdata[87:64];
    sprite.offset_x      = s_tdata[111:88];
    sprite.offset_y      = s_tdata[135:112];
    sprite.angle_deg     = s_tdata[152:136];
    sprite.tint_color    = s_tdata[184:153];
    sprite.flip_x        = s_tuser[0];
    sprite.flip_y        = s_tuser[1];
  end

  // texture rectangle registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uv.left   <= 16'h0000;
      uv.top    <= 16'h0000;
      uv.right  <= 16'hFFFF;
      uv.bottom <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_UV_LEFT:   uv.left   <= cfg_data;
        REG_UV_TOP:    uv.top    <= cfg_data;
        REG_UV_RIGHT:  uv.right  <= cfg_data;
        REG_UV_BOTTOM: uv.bottom <= cfg_data;
        default:       uv        <= uv;
      endcase
    end
  end

  sqv_front #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sprite (sprite),
    .uv        (uv),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_item  (f_item)
  );

  sqv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid && !q_full),
    .push_item  (f_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  sqv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
